// ===== hdl/assert_macros.svh =====
// assertion macros shared by the route lookup rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lprl assertion failed");

// next-cycle implication, disabled during reset
`define LPRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lprl assertion failed");

`endif

// ===== hdl/lprl_pkg.sv =====
// types, codes and helpers for the longest prefix route lookup
// no dependencies
package lprl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PORT_COUNT_DEF  = 8;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 6;
    localparam int PORT_W          = 3;
    localparam int TTL_W           = 8;
    localparam int STAT_W          = 3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FORWARDED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DROP_TTL  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NO_ROUTE  = 3'd4;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] route_prefix_addr;
        logic [LEN_W-1:0]  route_prefix_len;
        logic              route_has_hop;
        logic [ADDR_W-1:0] route_hop_addr;
        logic [PORT_W-1:0] route_port;
        logic [ADDR_W-1:0] dest_ip;
        logic [TTL_W-1:0]  ttl_in;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] hop_addr_out;
        logic [TTL_W-1:0]  ttl_out;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic              has_hop;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // leading-ones mask for a saturated prefix length
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_W{1'b1}} << (MAX_LEN - len);
        end
        return mask;
    endfunction

endpackage

// ===== hdl/lprl_table.sv =====
// route table storage: one write port, one read port with registered data
// depends on lprl_pkg
module lprl_table #(
    parameter int TABLE_DEPTH = lprl_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_W-1:0]    i_waddr,
    input  lprl_pkg::t_entry    i_wdata,
    input  logic                i_re,
    input  logic [IDX_W-1:0]    i_raddr,
    output lprl_pkg::t_entry    o_rdata
);

    lprl_pkg::t_entry r_mem [TABLE_DEPTH];
    lprl_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/longest_prefix_route_lookup_core.sv =====
// sequence: an add or ttl drop is resolved in exec; a lookup scans every stored route
// one entry per read, then drains and finishes (an empty table skips to finish)
// throughput: one item at a time; the next input is taken only once the previous result
// is loaded into the output register, which waits while the output is held
// reset: synchronous, active low; clears the route count and all control state,
// the table contents stay undefined until written
module longest_prefix_route_lookup_core #(
    parameter int TABLE_DEPTH = lprl_pkg::TABLE_DEPTH_DEF,
    parameter int PORT_COUNT  = lprl_pkg::PORT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lprl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lprl_pkg::t_out_item o_out_item
);

    `include "assert_macros.svh"

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    lprl_pkg::t_state    r_state, n_state;
    lprl_pkg::t_in_item  r_item;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_cmp_valid;
    logic                r_found;
    logic [lprl_pkg::LEN_W-1:0]  r_best_len;
    logic [lprl_pkg::PORT_W-1:0] r_best_port;
    logic [lprl_pkg::ADDR_W-1:0] r_best_hop;
    logic                r_out_valid;
    lprl_pkg::t_out_item r_out_item, n_out_item;

    logic             in_ready;
    logic             out_free;
    logic             out_load;
    logic             mem_we;
    logic             rd_en;
    logic             table_full;
    logic             ttl_drop;
    logic             rd_last;
    logic             cmp_match;
    logic             cmp_better;
    lprl_pkg::t_entry wr_entry;
    lprl_pkg::t_entry rd_entry;
    logic [lprl_pkg::ADDR_W-1:0] cmp_mask;

    assign out_free   = !r_out_valid || i_out_ready;
    assign table_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign ttl_drop   = (r_item.ttl_in <= 8'd1);
    assign rd_last    = (CNT_W'(r_rd_idx + 1'b1) == r_count);

    // saturate length and port on the way into the table
    always_comb begin
        wr_entry.prefix  = r_item.route_prefix_addr;
        wr_entry.length  = (r_item.route_prefix_len > lprl_pkg::MAX_LEN)
                           ? lprl_pkg::MAX_LEN : r_item.route_prefix_len;
        wr_entry.has_hop = r_item.route_has_hop;
        wr_entry.hop     = r_item.route_hop_addr;
        wr_entry.port    = (32'(r_item.route_port) >= 32'(PORT_COUNT))
                           ? lprl_pkg::PORT_W'(PORT_COUNT - 1) : r_item.route_port;
    end

    lprl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    // compare stage on the entry read last cycle; strict > keeps the earliest on ties
    always_comb begin
        cmp_mask   = lprl_pkg::prefix_mask(rd_entry.length);
        cmp_match  = (((r_item.dest_ip ^ rd_entry.prefix) & cmp_mask) == '0);
        cmp_better = r_cmp_valid && cmp_match && (!r_found || rd_entry.length > r_best_len);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lprl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lprl_pkg::S_EXEC;
                end
            end
            lprl_pkg::S_EXEC: begin
                if (r_item.command == lprl_pkg::CMD_ADD || ttl_drop) begin
                    if (out_free) begin
                        n_state = lprl_pkg::S_IDLE;
                    end
                end else if (r_count == '0) begin
                    n_state = lprl_pkg::S_FINISH;
                end else begin
                    n_state = lprl_pkg::S_SCAN;
                end
            end
            lprl_pkg::S_SCAN: begin
                if (rd_last) begin
                    n_state = lprl_pkg::S_DRAIN;
                end
            end
            lprl_pkg::S_DRAIN: begin
                n_state = lprl_pkg::S_FINISH;
            end
            lprl_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = lprl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lprl_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        n_out_item = '0;
        case (r_state)
            lprl_pkg::S_IDLE: begin
                in_ready = 1'b1;
            end
            lprl_pkg::S_EXEC: begin
                if (r_item.command == lprl_pkg::CMD_ADD) begin
                    out_load          = out_free;
                    mem_we            = out_free && !table_full;
                    n_out_item.status = table_full ? lprl_pkg::STAT_FULL
                                                   : lprl_pkg::STAT_ADDED;
                end else if (ttl_drop) begin
                    out_load          = out_free;
                    n_out_item.status = lprl_pkg::STAT_DROP_TTL;
                end
            end
            lprl_pkg::S_SCAN: begin
                rd_en = (r_rd_idx < r_count);
            end
            lprl_pkg::S_DRAIN: begin
                rd_en = 1'b0;
            end
            lprl_pkg::S_FINISH: begin
                out_load = out_free;
                if (r_found) begin
                    n_out_item.status       = lprl_pkg::STAT_FORWARDED;
                    n_out_item.out_port     = r_best_port;
                    n_out_item.hop_addr_out = r_best_hop;
                    n_out_item.ttl_out      = r_item.ttl_in - 8'd1;
                end else begin
                    n_out_item.status = lprl_pkg::STAT_NO_ROUTE;
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lprl_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= rd_en;
            if (mem_we) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (r_state == lprl_pkg::S_EXEC) begin
                r_rd_idx <= '0;
                r_found  <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_rd_idx <= CNT_W'(r_rd_idx + 1'b1);
                end
                if (cmp_better) begin
                    r_found <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (cmp_better) begin
            r_best_len  <= rd_entry.length;
            r_best_port <= rd_entry.port;
            r_best_hop  <= rd_entry.has_hop ? rd_entry.hop : r_item.dest_ip;
        end
        if (out_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `LPRL_ASSERT_NOW(a_write_only_on_add, i_clk, i_rst_n, mem_we,
        r_state == lprl_pkg::S_EXEC && r_item.command == lprl_pkg::CMD_ADD && !table_full)
    `LPRL_ASSERT_NEXT(a_count_follows_write, i_clk, i_rst_n, mem_we,
        r_count == CNT_W'($past(r_count) + 1'b1))
    `LPRL_ASSERT_NOW(a_read_below_count, i_clk, i_rst_n, rd_en, r_rd_idx < r_count)
    `LPRL_ASSERT_NOW(a_forward_has_ttl, i_clk, i_rst_n,
        r_out_valid && r_out_item.status == lprl_pkg::STAT_FORWARDED,
        r_out_item.ttl_out != 8'd0)

endmodule

// ===== dv/lprl_checker.sv =====
`timescale 1ns / 1ps
// result checker for longest_prefix_route_lookup_core: keeps its own copy of the route
// table, predicts each result from the input transfers and compares the output transfers
// depends on lprl_pkg
module lprl_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lprl_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lprl_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_forwarded
);

    localparam int MAX_REPORTS = 40;

    lprl_pkg::t_entry    routes [lprl_pkg::TABLE_DEPTH_DEF];
    int                  route_count = 0;
    lprl_pkg::t_out_item pending_results [$];
    int                  fail_count = 0;
    int                  pending_count = 0;
    int                  checked_count = 0;
    int                  forwarded_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;
    assign o_forwarded  = forwarded_count;

    task automatic report_mismatch(input string what,
                                   input logic [lprl_pkg::ADDR_W-1:0] got,
                                   input logic [lprl_pkg::ADDR_W-1:0] want);
        if (fail_count < MAX_REPORTS) begin
            $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    function automatic logic [lprl_pkg::ADDR_W-1:0] len_mask(
        input logic [lprl_pkg::LEN_W-1:0] len);
        logic [lprl_pkg::ADDR_W-1:0] mask;
        mask = '0;
        if (len != '0) begin
            mask = {lprl_pkg::ADDR_W{1'b1}} << (lprl_pkg::ADDR_W - int'(len));
        end
        return mask;
    endfunction

    // adds update the table; lookups scan it and keep the first of the longest matches
    function automatic lprl_pkg::t_out_item forward_decision(input lprl_pkg::t_in_item item);
        lprl_pkg::t_out_item res;
        lprl_pkg::t_entry    slot;
        logic                found;
        int                  best;
        int                  i;
        res   = '0;
        found = 1'b0;
        best  = 0;
        if (item.command == lprl_pkg::CMD_ADD) begin
            if (route_count >= lprl_pkg::TABLE_DEPTH_DEF) begin
                res.status = lprl_pkg::STAT_FULL;
            end else begin
                slot.prefix  = item.route_prefix_addr;
                slot.length  = (item.route_prefix_len > lprl_pkg::MAX_LEN)
                               ? lprl_pkg::MAX_LEN : item.route_prefix_len;
                slot.has_hop = item.route_has_hop;
                slot.hop     = item.route_hop_addr;
                slot.port    = (int'(item.route_port) >= lprl_pkg::PORT_COUNT_DEF)
                               ? lprl_pkg::PORT_W'(lprl_pkg::PORT_COUNT_DEF - 1)
                               : item.route_port;
                routes[route_count] = slot;
                route_count++;
                res.status = lprl_pkg::STAT_ADDED;
            end
        end else if (item.ttl_in <= lprl_pkg::TTL_W'(1)) begin
            res.status = lprl_pkg::STAT_DROP_TTL;
        end else begin
            for (i = 0; i < route_count; i++) begin
                if ((item.dest_ip & len_mask(routes[i].length)) ==
                    (routes[i].prefix & len_mask(routes[i].length))) begin
                    if (!found || routes[i].length > routes[best].length) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                res.status = lprl_pkg::STAT_NO_ROUTE;
            end else begin
                res.status       = lprl_pkg::STAT_FORWARDED;
                res.out_port     = routes[best].port;
                res.hop_addr_out = routes[best].has_hop ? routes[best].hop : item.dest_ip;
                res.ttl_out      = item.ttl_in - lprl_pkg::TTL_W'(1);
            end
        end
        return res;
    endfunction

    // output side first, so a result in the same cycle as its input transfer is flagged
    always @(posedge i_clk) begin : watch_channels
        lprl_pkg::t_out_item want;
        if (!i_rst_n) begin
            route_count = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with nothing pending, status",
                                    lprl_pkg::ADDR_W'(i_out_item.status), '0);
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.status == lprl_pkg::STAT_FORWARDED) begin
                        forwarded_count++;
                    end
                    if (i_out_item.status !== want.status) begin
                        report_mismatch("status", lprl_pkg::ADDR_W'(i_out_item.status),
                                        lprl_pkg::ADDR_W'(want.status));
                    end
                    if (i_out_item.out_port !== want.out_port) begin
                        report_mismatch("out_port", lprl_pkg::ADDR_W'(i_out_item.out_port),
                                        lprl_pkg::ADDR_W'(want.out_port));
                    end
                    if (i_out_item.hop_addr_out !== want.hop_addr_out) begin
                        report_mismatch("hop_addr_out", i_out_item.hop_addr_out,
                                        want.hop_addr_out);
                    end
                    if (i_out_item.ttl_out !== want.ttl_out) begin
                        report_mismatch("ttl_out", lprl_pkg::ADDR_W'(i_out_item.ttl_out),
                                        lprl_pkg::ADDR_W'(want.ttl_out));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results = {pending_results, forward_decision(i_in_item)};
            end
        end
        pending_count = pending_results.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// top of the route lookup testbench: clock, reset, stimulus and verdict
// depends on lprl_pkg, longest_prefix_route_lookup_core and lprl_checker
module tb_top;

    localparam int RANDOM_ITEMS  = 780;
    localparam int QUIET_ITEMS   = 150;
    localparam int LEN_FIELD_MAX = (1 << lprl_pkg::LEN_W) - 1;
    localparam int SETTLE_CYCLES = 2 * lprl_pkg::TABLE_DEPTH_DEF + 8;
    localparam int CYCLE_LIMIT   = 300000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    lprl_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lprl_pkg::t_out_item out_item;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   forwarded_count;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic sender_idles = 1'b0;
    logic sink_stalls = 1'b0;
    int   adds_sent = 0;
    int   lookups_sent = 0;

    // routes the table should hold, used only to aim destinations at stored prefixes
    logic [lprl_pkg::ADDR_W-1:0] known_prefix [lprl_pkg::TABLE_DEPTH_DEF];
    int                          known_len [lprl_pkg::TABLE_DEPTH_DEF];
    int                          known_count = 0;

    always #10 clk = ~clk;

    longest_prefix_route_lookup_core #(
        .TABLE_DEPTH(lprl_pkg::TABLE_DEPTH_DEF),
        .PORT_COUNT (lprl_pkg::PORT_COUNT_DEF)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    lprl_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count),
        .o_forwarded (forwarded_count)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_count);
            $display("longest_prefix_route_lookup_core regression: fail");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [lprl_pkg::ADDR_W-1:0] net_mask(input int len);
        logic [lprl_pkg::ADDR_W-1:0] mask;
        mask = '0;
        if (len > 0) begin
            mask = {lprl_pkg::ADDR_W{1'b1}} << (lprl_pkg::ADDR_W - len);
        end
        return mask;
    endfunction

    // fields a command does not use still carry random values
    function automatic lprl_pkg::t_in_item scrambled_item();
        lprl_pkg::t_in_item item;
        item.command           = 1'($urandom);
        item.route_prefix_addr = $urandom;
        item.route_prefix_len  = lprl_pkg::LEN_W'($urandom_range(0, LEN_FIELD_MAX));
        item.route_has_hop     = 1'($urandom);
        item.route_hop_addr    = $urandom;
        item.route_port        = lprl_pkg::PORT_W'($urandom);
        item.dest_ip           = $urandom;
        item.ttl_in            = lprl_pkg::TTL_W'($urandom);
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input lprl_pkg::t_in_item item);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_add(input logic [lprl_pkg::ADDR_W-1:0] prefix, input int len,
                            input logic has_hop, input logic [lprl_pkg::ADDR_W-1:0] hop,
                            input logic [lprl_pkg::PORT_W-1:0] port);
        lprl_pkg::t_in_item item;
        item = scrambled_item();
        item.command           = lprl_pkg::CMD_ADD;
        item.route_prefix_addr = prefix;
        item.route_prefix_len  = lprl_pkg::LEN_W'(len);
        item.route_has_hop     = has_hop;
        item.route_hop_addr    = hop;
        item.route_port        = port;
        if (known_count < lprl_pkg::TABLE_DEPTH_DEF) begin
            known_prefix[known_count] = prefix;
            known_len[known_count]    = (len > lprl_pkg::ADDR_W) ? lprl_pkg::ADDR_W : len;
            known_count++;
        end
        adds_sent++;
        send_item(item);
    endtask

    task automatic send_route(input logic [lprl_pkg::ADDR_W-1:0] dest,
                              input logic [lprl_pkg::TTL_W-1:0] ttl);
        lprl_pkg::t_in_item item;
        item = scrambled_item();
        item.command = lprl_pkg::CMD_ROUTE;
        item.dest_ip = dest;
        item.ttl_in  = ttl;
        lookups_sent++;
        send_item(item);
    endtask

    // drop valid and hold off until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int                          n;
        int                          idx;
        int                          len;
        logic [lprl_pkg::ADDR_W-1:0] mask;
        logic [lprl_pkg::ADDR_W-1:0] prefix;
        logic [lprl_pkg::ADDR_W-1:0] dest;
        logic [lprl_pkg::TTL_W-1:0]  ttl;
        logic                        table_full;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, then ttl drops
        send_route(32'h0A01_0203, 8'd64);
        send_route(32'h0A01_0203, 8'd0);
        send_route(32'hFFFF_FFFF, 8'd1);
        send_add(32'h0A00_0000, 8, 1'b1, 32'hC000_0201, 3'd3);
        send_add(32'h0A01_0000, 16, 1'b0, 32'h0000_0000, 3'd7);
        // same prefix and length again: the earlier entry must keep winning
        send_add(32'h0A01_0000, 16, 1'b1, 32'hDEAD_BEEF, 3'd2);
        send_add(32'hFFFF_FFFF, 32, 1'b1, 32'h0102_0304, 3'd5);
        // length beyond 32 saturates
        send_add(32'h1234_5678, LEN_FIELD_MAX, 1'b0, 32'hFFFF_FFFF, 3'd1);
        // host bits set below the prefix length
        send_add(32'hC0A8_01FF, 24, 1'b1, 32'hC0A8_0101, 3'd6);
        send_add(32'h0000_0000, 32, 1'b1, 32'hFFFF_FFFF, 3'd0);
        send_route(32'h0A01_0203, 8'd255);
        send_route(32'h0A02_0304, 8'd2);
        send_route(32'hFFFF_FFFF, 8'd128);
        send_route(32'h1234_5678, 8'd3);
        send_route(32'h1234_5679, 8'd3);
        send_route(32'hC0A8_0142, 8'd17);
        send_route(32'h0000_0000, 8'd200);
        send_route(32'h0B00_0000, 8'd10);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                sender_idles = ($urandom_range(0, 3) != 0);
                sink_stalls  = ($urandom_range(0, 3) != 0);
            end
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                sender_idles = 1'b0;
                sink_stalls  = 1'b0;
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            table_full = (known_count >= lprl_pkg::TABLE_DEPTH_DEF);
            if (table_full ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) == 0)) begin
                len = $urandom_range(1, lprl_pkg::ADDR_W);
                if ($urandom_range(0, 5) == 0) begin
                    len = $urandom_range(lprl_pkg::ADDR_W + 1, LEN_FIELD_MAX);
                end
                prefix = $urandom;
                // nest under a stored route, sometimes at the same length for a tie
                if (known_count > 0 && $urandom_range(0, 1) == 1) begin
                    idx    = $urandom_range(0, known_count - 1);
                    mask   = net_mask(known_len[idx]);
                    prefix = (known_prefix[idx] & mask) | (prefix & ~mask);
                    if ($urandom_range(0, 2) == 0) begin
                        len = known_len[idx];
                    end
                end
                // default route takes the last free slot so misses stay reachable until then
                if (known_count == lprl_pkg::TABLE_DEPTH_DEF - 1) begin
                    len = 0;
                end
                send_add(prefix, len, 1'($urandom), $urandom,
                         lprl_pkg::PORT_W'($urandom));
            end else begin
                ttl = lprl_pkg::TTL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                                   : $urandom_range(2, 255));
                dest = $urandom;
                if (known_count > 0 && $urandom_range(0, 9) < 7) begin
                    idx  = $urandom_range(0, known_count - 1);
                    mask = net_mask(known_len[idx]);
                    dest = (known_prefix[idx] & mask) | (dest & ~mask);
                    // flip the last prefix bit for a near miss
                    if (known_len[idx] > 0 && $urandom_range(0, 3) == 0) begin
                        dest = dest ^ (32'h1 << (lprl_pkg::ADDR_W - known_len[idx]));
                    end
                end
                send_route(dest, ttl);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("sent %0d route adds (table filled, then refusals) and %0d datagram lookups",
                 adds_sent, lookups_sent);
        $display("compared %0d results, %0d of them forwarded", checked_count,
                 forwarded_count);
        if (fail_count == 0) begin
            $display("longest_prefix_route_lookup_core regression: pass");
        end else begin
            $display("longest_prefix_route_lookup_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lprl_pkg.sv
hdl/lprl_table.sv
hdl/longest_prefix_route_lookup_core.sv
dv/lprl_checker.sv
dv/tb_top.sv
